[hw/rtl/mtt_pkg.sv]
package mtt_pkg;

   // Characters of the tag syntax.
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2D;

   localparam logic [1:0] CLASS_OTHER = 2'd0;
   localparam logic [1:0] CLASS_TAG   = 2'd1;
   localparam logic [1:0] CLASS_ATTR  = 2'd2;
   localparam logic [1:0] CLASS_VALUE = 2'd3;

   localparam logic [1:0] STATUS_BUSY  = 2'd0;
   localparam logic [1:0] STATUS_OK    = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   typedef enum logic [8:0] {
      ST_START     = 9'b000000001,
      ST_OPEN      = 9'b000000010,
      ST_NAME      = 9'b000000100,
      ST_END_ATTR  = 9'b000001000,
      ST_ATTR_NAME = 9'b000010000,
      ST_VAL_START = 9'b000100000,
      ST_VALUE     = 9'b001000000,
      ST_DONE      = 9'b010000000,
      ST_ERROR     = 9'b100000000
   } state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  ch_out;
      logic [1:0]  token_class;
      logic        name_end;
      logic        attr_name_end;
      logic        attr_value_end;
      logic        tag_done;
      logic        closing_tag;
      logic [1:0]  status;
      logic [15:0] error_position;
   } rsp_payload_type;

   typedef struct packed {
      state_type  next_state;
      logic       closing;
      logic [1:0] token_class;
      logic       name_end;
      logic       attr_name_end;
      logic       attr_value_end;
      logic       tag_done;
   } step_type;

   function automatic logic is_name_byte(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) || c == CH_DASH;
   endfunction

endpackage

[hw/rtl/mtt_stream_if.sv]
interface mtt_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/mtt_step.sv]
module mtt_step (
   input  mtt_pkg::state_type state,
   input  logic               closing_flag,
   input  logic [7:0]         ch,
   output mtt_pkg::step_type  step
);
   import mtt_pkg::*;

   state_type cur;
   logic      go;

   // A byte after '<' that is not '/' and a byte that ends the tag name are
   // handled again in the following state within the same transaction.
   always_comb begin
      step = '0;
      step.next_state = state;
      step.closing = closing_flag;
      step.token_class = CLASS_OTHER;
      cur = state;
      go = (state != ST_ERROR);

      if (go && cur == ST_OPEN) begin
         step.next_state = ST_NAME;
         if (ch == CH_SLASH) begin
            step.closing = 1'b1;
            go = 1'b0;
         end else begin
            cur = ST_NAME;
         end
      end

      if (go && cur == ST_NAME) begin
         if (is_name_byte(ch)) begin
            step.token_class = CLASS_TAG;
            step.next_state = ST_NAME;
            go = 1'b0;
         end else begin
            step.name_end = 1'b1;
            cur = ST_END_ATTR;
         end
      end

      if (go) begin
         unique case (cur)
            ST_START: begin
               step.next_state = (ch == CH_LT) ? ST_OPEN : ST_ERROR;
            end
            ST_END_ATTR: begin
               if (ch == CH_SPACE) begin
                  step.next_state = ST_ATTR_NAME;
               end else if (ch == CH_GT) begin
                  step.next_state = ST_DONE;
                  step.tag_done = 1'b1;
               end else begin
                  step.next_state = ST_ERROR;
               end
            end
            ST_ATTR_NAME: begin
               if (is_name_byte(ch)) begin
                  step.token_class = CLASS_ATTR;
                  step.next_state = ST_ATTR_NAME;
               end else if (ch == CH_EQ) begin
                  step.attr_name_end = 1'b1;
                  step.next_state = ST_VAL_START;
               end else begin
                  step.next_state = ST_ERROR;
               end
            end
            ST_VAL_START: begin
               step.next_state = (ch == CH_QUOTE) ? ST_VALUE : ST_ERROR;
            end
            ST_VALUE: begin
               if (ch == CH_QUOTE) begin
                  step.attr_value_end = 1'b1;
                  step.next_state = ST_END_ATTR;
               end else begin
                  step.token_class = CLASS_VALUE;
                  step.next_state = ST_VALUE;
               end
            end
            default: begin
               step.next_state = cur;
            end
         endcase
      end
   end

endmodule

[hw/rtl/markup_tag_tokenizer.sv]
// Markup tag tokenizer.
// The req channel carries one byte of a tag per transaction together with a
// last flag that marks the final byte of the string. The rsp channel returns
// one transaction per byte: the echoed byte, its token class, the end flags
// for tag name, attribute name, attribute value and the closing '>', the
// closing-tag flag, the string status and the position of the first error.
// A byte is registered in the input register at acceptance; its result is
// registered in the result register once that is free, raising rsp.valid.
// The block takes one byte per clock while rsp.ready is high; the
// combinational next-state logic on the parser state bounds the rate, since
// each byte depends on the state the previous byte left.
// The final byte reports ok or error and returns the parser to its start.
// Reset is synchronous and clears the parser state and both stages.
// When rsp.ready is low, the result register holds and the input register
// fills; req.ready then drops until the result is taken.
module markup_tag_tokenizer #(
   parameter longint unsigned MAX_LENGTH = 65536
) (
   input logic         clock,
   input logic         reset,
   mtt_stream_if.sink  req,
   mtt_stream_if.source rsp
);
   import mtt_pkg::*;

   localparam longint unsigned CAP_WIDE =
      (MAX_LENGTH - 64'd1 < 64'hFFFF) ? (MAX_LENGTH - 64'd1) : 64'hFFFF;
   localparam logic [15:0] IDX_CAP = CAP_WIDE[15:0];

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff, in_data_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;

   state_type   state_ff, state_in;
   logic        closing_ff, closing_in;
   logic [15:0] byte_index_ff, byte_index_in;
   logic [15:0] error_index_ff, error_index_in;

   step_type step;
   logic     out_free;
   logic     advance;
   logic     now_error;
   logic     new_error;

   mtt_step u_step (
      .state        (state_ff),
      .closing_flag (closing_ff),
      .ch           (in_data_ff.ch),
      .step         (step)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   assign now_error = (step.next_state == ST_ERROR);
   assign new_error = now_error && (state_ff != ST_ERROR);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req.payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in.ch_out         = in_data_ff.ch;
         out_data_in.token_class    = step.token_class;
         out_data_in.name_end       = step.name_end;
         out_data_in.attr_name_end  = step.attr_name_end;
         out_data_in.attr_value_end = step.attr_value_end;
         out_data_in.tag_done       = step.tag_done;
         out_data_in.closing_tag    = step.closing;
         if (!in_data_ff.last) begin
            out_data_in.status = STATUS_BUSY;
         end else if (now_error) begin
            out_data_in.status = STATUS_ERROR;
         end else begin
            out_data_in.status = STATUS_OK;
         end
         if (new_error) begin
            out_data_in.error_position = byte_index_ff;
         end else if (now_error) begin
            out_data_in.error_position = error_index_ff;
         end else begin
            out_data_in.error_position = '0;
         end
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      closing_in     = closing_ff;
      byte_index_in  = byte_index_ff;
      error_index_in = error_index_ff;
      if (advance) begin
         if (in_data_ff.last) begin
            state_in       = ST_START;
            closing_in     = 1'b0;
            byte_index_in  = '0;
            error_index_in = '0;
         end else begin
            state_in   = step.next_state;
            closing_in = step.closing;
            if (byte_index_ff < IDX_CAP) begin
               byte_index_in = byte_index_ff + 16'd1;
            end
            if (new_error) begin
               error_index_in = byte_index_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff       <= ST_START;
         closing_ff     <= 1'b0;
         byte_index_ff  <= '0;
         error_index_ff <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         state_ff       <= state_in;
         closing_ff     <= closing_in;
         byte_index_ff  <= byte_index_in;
         error_index_ff <= error_index_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_data_ff;

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ERROR && !(advance && in_data_ff.last) |=> $stable(error_index_ff)
   ) else $error("error position changed after the first error");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.last |=> state_ff == ST_START && byte_index_ff == 16'd0
   ) else $error("parser did not restart after the final byte");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff)
   ) else $error("stalled input register was overwritten");

   a_done_state: assert property (@(posedge clock) disable iff (reset)
      advance && step.tag_done && !in_data_ff.last |=> state_ff == ST_DONE
   ) else $error("closing bracket did not finish the tag");

endmodule

[test/markup_tag_tokenizer_test.sv]
module markup_tag_tokenizer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mtt_pkg::*;

   localparam longint unsigned TAG_MAX_LENGTH = 65536;
   localparam int unsigned INDEX_CAP =
      (TAG_MAX_LENGTH - 1 < 65535) ? int'(TAG_MAX_LENGTH - 1) : 65535;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_BYTES = 1320;
   localparam int CALM_BYTES = 200;
   localparam int HOLD_AFTER = 400;
   localparam int HOLD_CYCLES = 60;

   class tag_scoreboard;
      state_type       parse_state;
      bit              closing;
      int unsigned     byte_index;
      bit              error_seen;
      logic [15:0]     error_index;
      rsp_payload_type expected_q[$];
      int              failures;

      function new();
         restart();
         failures = 0;
      endfunction

      function void restart();
         parse_state = ST_START;
         closing = 1'b0;
         byte_index = 0;
         error_seen = 1'b0;
         error_index = '0;
      endfunction

      function bit name_char(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == CH_DASH;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Works out the result of one accepted byte and advances the parser.
      function void note_byte(req_payload_type t);
         rsp_payload_type r;
         state_type       s;
         bit              again;
         r = '0;
         r.ch_out = t.ch;
         if (!error_seen) begin
            s = parse_state;
            again = 1'b1;
            while (again) begin
               again = 1'b0;
               case (s)
                  ST_START: begin
                     s = (t.ch == CH_LT) ? ST_OPEN : ST_ERROR;
                  end
                  ST_OPEN: begin
                     s = ST_NAME;
                     if (t.ch == CH_SLASH) begin
                        closing = 1'b1;
                     end else begin
                        again = 1'b1;
                     end
                  end
                  ST_NAME: begin
                     if (name_char(t.ch)) begin
                        r.token_class = CLASS_TAG;
                     end else begin
                        r.name_end = 1'b1;
                        s = ST_END_ATTR;
                        again = 1'b1;
                     end
                  end
                  ST_END_ATTR: begin
                     if (t.ch == CH_SPACE) begin
                        s = ST_ATTR_NAME;
                     end else if (t.ch == CH_GT) begin
                        s = ST_DONE;
                        r.tag_done = 1'b1;
                     end else begin
                        s = ST_ERROR;
                     end
                  end
                  ST_ATTR_NAME: begin
                     if (name_char(t.ch)) begin
                        r.token_class = CLASS_ATTR;
                     end else if (t.ch == CH_EQ) begin
                        r.attr_name_end = 1'b1;
                        s = ST_VAL_START;
                     end else begin
                        s = ST_ERROR;
                     end
                  end
                  ST_VAL_START: begin
                     s = (t.ch == CH_QUOTE) ? ST_VALUE : ST_ERROR;
                  end
                  ST_VALUE: begin
                     if (t.ch == CH_QUOTE) begin
                        r.attr_value_end = 1'b1;
                        s = ST_END_ATTR;
                     end else begin
                        r.token_class = CLASS_VALUE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (s == ST_ERROR) begin
               error_seen = 1'b1;
               error_index = byte_index[15:0];
            end
            parse_state = s;
         end
         r.closing_tag = closing;
         if (t.last) begin
            r.status = error_seen ? STATUS_ERROR : STATUS_OK;
         end else begin
            r.status = STATUS_BUSY;
         end
         r.error_position = error_seen ? error_index : 16'd0;
         if (byte_index < INDEX_CAP) begin
            byte_index++;
         end
         if (t.last) begin
            restart();
         end
         expected_q.push_back(r);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            $error("result with ch_out %0h arrived with nothing expected", got.ch_out);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("ch_out", want.ch_out, got.ch_out);
         compare_field("token_class", want.token_class, got.token_class);
         compare_field("name_end", want.name_end, got.name_end);
         compare_field("attr_name_end", want.attr_name_end, got.attr_name_end);
         compare_field("attr_value_end", want.attr_value_end, got.attr_value_end);
         compare_field("tag_done", want.tag_done, got.tag_done);
         compare_field("closing_tag", want.closing_tag, got.closing_tag);
         compare_field("status", want.status, got.status);
         compare_field("error_position", want.error_position, got.error_position);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mtt_stream_if #(.payload_type(req_payload_type)) req_if ();
   mtt_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   markup_tag_tokenizer #(.MAX_LENGTH(TAG_MAX_LENGTH)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if)
   );

   tag_scoreboard sb = new();
   int  sent_count = 0;
   int  idle_cycles = 0;
   bit  idle_on = 1'b0;
   bit  final_part = 1'b0;
   bit  hold_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_byte(req_if.payload);
            sent_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_result(rsp_if.payload);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The receiver stalls in random bursts, and once for a long stretch so that
   // the block fills up and holds off its input.
   initial begin
      int low_left;
      low_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (!hold_done && sent_count >= HOLD_AFTER) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
            rsp_if.ready <= 1'b1;
         end else if (low_left > 0) begin
            rsp_if.ready <= 1'b0;
            low_left--;
         end else if (idle_on && !final_part && $urandom_range(7) == 0) begin
            low_left = $urandom_range(15);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(logic [7:0] c, logic last);
      req_if.valid <= 1'b1;
      req_if.payload <= '{ch: c, last: last};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (idle_on && !final_part && $urandom_range(7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic send_seq(logic [7:0] s[$]);
      foreach (s[i]) begin
         send_byte(s[i], i == s.size() - 1);
      end
   endtask

   task automatic send_text(string txt);
      for (int i = 0; i < txt.len(); i++) begin
         send_byte(txt[i], i == txt.len() - 1);
      end
   endtask

   function automatic logic [7:0] pick_name_char();
      case ($urandom_range(2))
         0: return "a" + $urandom_range(25);
         1: return "0" + $urandom_range(9);
         default: return CH_DASH;
      endcase
   endfunction

   function automatic logic [7:0] pick_value_byte();
      logic [7:0] c;
      do begin
         c = $urandom_range(255);
      end while (c == CH_QUOTE);
      return c;
   endfunction

   // Mostly well-formed tags with random content; some are pure noise,
   // corrupted at one byte or cut short.
   function automatic void build_tag(ref logic [7:0] s[$]);
      int len;
      s.delete();
      if ($urandom_range(9) == 0) begin
         len = $urandom_range(1, 6);
         repeat (len) s.push_back($urandom_range(255));
         return;
      end
      s.push_back(CH_LT);
      if ($urandom_range(3) == 0) begin
         s.push_back(CH_SLASH);
      end
      repeat ($urandom_range(4)) s.push_back(pick_name_char());
      repeat ($urandom_range(3)) begin
         s.push_back(CH_SPACE);
         repeat ($urandom_range(4)) s.push_back(pick_name_char());
         s.push_back(CH_EQ);
         s.push_back(CH_QUOTE);
         repeat ($urandom_range(5)) s.push_back(pick_value_byte());
         s.push_back(CH_QUOTE);
      end
      if ($urandom_range(9) != 0) begin
         s.push_back(CH_GT);
      end
      repeat ($urandom_range(2)) s.push_back($urandom_range(255));
      if ($urandom_range(6) == 0) begin
         s[$urandom_range(s.size() - 1)] = $urandom_range(255);
      end
      if ($urandom_range(9) == 0 && s.size() > 1) begin
         s = s[0:$urandom_range(s.size() - 2)];
      end
   endfunction

   initial begin
      logic [7:0] s[$];
      int         sent_start;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      send_text("<>");
      send_text("< =\"\">");
      send_text("</z- k=\"v\">x");
      send_text("x");
      send_text("<a!q");
      send_text("<a b");

      sent_start = sent_count;
      while (sent_count - sent_start < RANDOM_BYTES) begin
         build_tag(s);
         idle_on = $urandom_range(3) != 0;
         final_part = sent_count - sent_start >= RANDOM_BYTES - CALM_BYTES;
         send_seq(s);
      end
      req_if.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
